/* design/cbvd_pkg.sv */
// Shared types, constants and colour conversion for the block video decoder.
// Used by every module of the design; depends on nothing else.
package cbvd_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 1024;

  // Grid sizes need one bit more than a block column or row index.
  localparam int unsigned GridW = $clog2(MaxWidth / 4 + 1);

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_OUT_FORMAT   = 2'd2;

  localparam logic [10:0] WIDTH_RST  = 11'd320;
  localparam logic [10:0] HEIGHT_RST = 11'd240;

  localparam logic [15:0] SKIP_MASK = 16'hFC00;
  localparam logic [15:0] SKIP_CODE = 16'h8400;

  // Front end parse phases.
  localparam logic [2:0] PH_OPCODE = 3'd0;
  localparam logic [2:0] PH_COLOR0 = 3'd1;
  localparam logic [2:0] PH_PAIR   = 3'd2;
  localparam logic [2:0] PH_QUAD   = 3'd3;

  // One decoded block, ready to be expanded into four pixel rows.
  typedef struct packed {
    logic [7:0]       col;
    logic [7:0]       row_base;  // frame row of the block divided by four
    logic             quad;
    logic [15:0]      mask;
    logic [7:0][14:0] colors;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic [31:0] conv_color(input logic fmt, input logic [14:0] c);
    logic [31:0] r;
    if (fmt) begin
      r = {17'd0, c[4:0], c[9:5], c[14:10]};
    end else begin
      r = {8'hFF, c[14:10], 3'd0, c[9:5], 3'd0, c[4:0], 3'd0};
    end
    return r;
  endfunction

endpackage

/* design/cbvd_front.sv */
// Front end: parses stream words, keeps the block position and colour store,
// and pushes decoded block descriptors into the queue. Depends on cbvd_pkg.
module cbvd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     cmd_i,
  input  logic [15:0]              word_i,
  input  logic [cbvd_pkg::GridW-1:0] cols_i,
  input  logic [cbvd_pkg::GridW-1:0] rows_i,
  input  cbvd_pkg::fifo_stat_t     q_stat_i,
  output logic                     push_o,
  output cbvd_pkg::desc_t          desc_o
);
  import cbvd_pkg::*;

  logic [2:0]       phase_q, phase_d;
  logic [15:0]      mask_q, mask_d;
  logic [7:0][14:0] colors_q, colors_d;
  logic [3:0]       need_q, need_d;
  logic [7:0]       col_q, col_d;
  logic [7:0]       row_q, row_d;
  logic             done_q, done_d;
  logic             skip_q, skip_d;
  logic [10:0]      bx_q, bx_d;

  logic             accept;
  logic             invalid;
  logic             quad;
  logic [3:0]       total;
  logic [3:0]       need_fix;
  logic [3:0]       need_dec;
  logic [2:0]       cidx;
  logic [GridW-1:0] col_inc;
  logic [GridW-1:0] row_inc;
  logic [GridW-1:0] row_diff;

  assign in_ready_o = !skip_q && !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;
  assign invalid    = (cols_i == '0) || (rows_i == '0) || done_q ||
                      ({1'b0, col_q} >= cols_i) || ({1'b0, row_q} >= rows_i);

  assign quad     = (phase_q == PH_QUAD);
  assign total    = quad ? 4'd8 : 4'd2;
  assign need_fix = ((need_q == 4'd0) || (need_q >= total)) ? total - 4'd1 : need_q;
  assign need_dec = need_fix - 4'd1;
  assign cidx     = 3'(total - need_fix);
  assign col_inc  = {1'b0, col_q} + GridW'(1);
  assign row_inc  = {1'b0, row_q} + GridW'(1);
  assign row_diff = rows_i - GridW'(1) - {1'b0, row_q};

  always_comb begin
    phase_d  = phase_q;
    mask_d   = mask_q;
    colors_d = colors_q;
    need_d   = need_q;
    col_d    = col_q;
    row_d    = row_q;
    done_d   = done_q;
    skip_d   = skip_q;
    bx_d     = bx_q;
    push_o   = 1'b0;
    desc_o.col      = col_q;
    desc_o.row_base = row_diff[7:0];
    desc_o.quad     = quad;
    desc_o.mask     = mask_q;
    desc_o.colors   = colors_q;

    if (skip_q) begin
      // One wrap per cycle until the target column lies inside the row or the frame ends.
      if ({2'b00, cols_i} <= bx_q) begin
        bx_d = bx_q - {2'b00, cols_i};
        if (row_inc >= rows_i) begin
          done_d = 1'b1;
          col_d  = '0;
          row_d  = '0;
          skip_d = 1'b0;
        end else begin
          row_d = row_inc[7:0];
        end
      end else begin
        col_d  = bx_q[7:0];
        skip_d = 1'b0;
      end
    end else if (accept) begin
      if (cmd_i) begin
        phase_d = PH_OPCODE;
        need_d  = '0;
        col_d   = '0;
        row_d   = '0;
        done_d  = 1'b0;
      end else if (invalid) begin
        done_d  = 1'b1;
        phase_d = PH_OPCODE;
        need_d  = '0;
      end else begin
        unique case (phase_q)
          PH_COLOR0: begin
            colors_d[0] = word_i[14:0];
            need_d      = word_i[15] ? 4'd7 : 4'd1;
            phase_d     = word_i[15] ? PH_QUAD : PH_PAIR;
          end
          PH_PAIR, PH_QUAD: begin
            colors_d[cidx] = word_i[14:0];
            need_d         = need_dec;
            if (need_dec == 4'd0) begin
              push_o        = 1'b1;
              desc_o.colors = colors_d;
              phase_d       = PH_OPCODE;
            end
          end
          default: begin
            phase_d = PH_OPCODE;
            if (word_i[15]) begin
              if ((word_i & SKIP_MASK) == SKIP_CODE) begin
                skip_d = 1'b1;
                bx_d   = {3'b000, col_q} + {1'b0, word_i[9:0]};
              end else begin
                push_o        = 1'b1;
                desc_o.quad   = 1'b0;
                desc_o.mask   = '1;
                desc_o.colors = {8{word_i[14:0]}};
              end
            end else begin
              mask_d  = word_i;
              phase_d = PH_COLOR0;
            end
          end
        endcase
        // A finished block moves the position on by one block.
        if (push_o) begin
          if (col_inc >= cols_i) begin
            col_d = '0;
            if (row_inc >= rows_i) begin
              done_d = 1'b1;
              row_d  = '0;
            end else begin
              row_d = row_inc[7:0];
            end
          end else begin
            col_d = col_inc[7:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OPCODE;
      mask_q  <= '0;
      need_q  <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
      skip_q  <= 1'b0;
      bx_q    <= '0;
    end else begin
      phase_q <= phase_d;
      mask_q  <= mask_d;
      need_q  <= need_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
      skip_q  <= skip_d;
      bx_q    <= bx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    colors_q <= colors_d;
  end

  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_stat_i.full)
    else $error("block pushed into a full queue");

  a_skip_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skip_q) |-> $past(accept && !cmd_i && word_i[15]))
    else $error("skip started without a skip word");

  a_skip_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skip_q |-> !push_o && (phase_q == PH_OPCODE))
    else $error("block decoded during a skip");

endmodule

/* design/cbvd_queue.sv */
// Two-entry queue of block descriptors between the parser and the row emitter.
// Depends on cbvd_pkg for the descriptor type.
module cbvd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  cbvd_pkg::desc_t      desc_i,
  input  logic                 pop_i,
  output cbvd_pkg::desc_t      head_o,
  output cbvd_pkg::fifo_stat_t stat_o
);
  import cbvd_pkg::*;

  desc_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign head_o       = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= desc_i;
    end
  end

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty block queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("block queue count out of range");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_q == rd_q))
    else $error("block queue pointers disagree with count");

endmodule

/* design/cbvd_back.sv */
// Row emitter: expands each queued block into four pixel rows and holds
// them in an output register. Depends on cbvd_pkg.
module cbvd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbvd_pkg::desc_t      head_i,
  input  cbvd_pkg::fifo_stat_t q_stat_i,
  output logic                 pop_o,
  input  logic                 out_format_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [7:0]           block_col_o,
  output logic [9:0]           pixel_row_o,
  output logic [31:0]          pix0_o,
  output logic [31:0]          pix1_o,
  output logic [31:0]          pix2_o,
  output logic [31:0]          pix3_o,
  output logic                 block_end_o
);
  import cbvd_pkg::*;

  logic [1:0]       k_q;
  logic             valid_q;
  logic             adv;
  logic [3:0][31:0] pix_d;
  logic [3:0][31:0] pix_q;
  logic [7:0]       col_q;
  logic [9:0]       prow_q;
  logic             end_q;

  assign adv   = !q_stat_i.empty && (!valid_q || out_ready_i);
  assign pop_o = adv && (k_q == 2'd3);

  // In a quadrant block each pixel picks its pair by quadrant; then the colour by its mask bit.
  always_comb begin
    logic       bit_sel;
    logic [2:0] idx;
    for (int i = 0; i < 4; i++) begin
      bit_sel  = head_i.mask[{k_q, 2'(i)}];
      idx      = head_i.quad ? {k_q[1], (i >= 2), !bit_sel} : {2'b00, !bit_sel};
      pix_d[i] = conv_color(out_format_i, head_i.colors[idx]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q     <= '0;
      valid_q <= 1'b0;
    end else begin
      if (adv) begin
        k_q     <= k_q + 2'd1;
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pix_q  <= pix_d;
      col_q  <= head_i.col;
      prow_q <= {head_i.row_base, ~k_q};
      end_q  <= (k_q == 2'd3);
    end
  end

  assign out_valid_o = valid_q;
  assign block_col_o = col_q;
  assign pixel_row_o = prow_q;
  assign pix0_o      = pix_q[0];
  assign pix1_o      = pix_q[1];
  assign pix2_o      = pix_q[2];
  assign pix3_o      = pix_q[3];
  assign block_end_o = end_q;

  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> valid_q && (end_q == ($past(k_q) == 2'd3)))
    else $error("block end flag out of step with row count");

  a_block_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0) |-> !q_stat_i.empty)
    else $error("block queue emptied in the middle of a block");

  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && (k_q != 2'd0)) |=> (pixel_row_o == $past(prow_q) - 10'd1))
    else $error("pixel rows of a block not consecutive");

endmodule

/* design/cram_block_video_decoder.sv */
// Top level of the 16-bit block video decoder: configuration registers,
// parser front end, block queue and row emitter. Depends on cbvd_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------
//   in      | input     | in_valid_i/in_ready_o  | cmd_i, word_i
//   out     | output    | out_valid_o/out_ready_i| block_col_o, pixel_row_o,
//           |           |                        | pix0_o..pix3_o, block_end_o
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A word is accepted whenever no skip is in progress and the queue has room;
// a block is ready after its last word (one word for a fill, three or nine for
// a masked block). The row emitter sends one row a cycle while the receiver is ready,
// so a block occupies the output for four beats; a two-block queue lets the parser
// run ahead while rows drain, and the input waits while both entries are held.
// A skip word holds the input, one row wrap per cycle, until the target column lies
// inside a row or the frame ends. Reset is asynchronous and needs no clearing pass.
module cram_block_video_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] word_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  block_col_o,
  output logic [9:0]  pixel_row_o,
  output logic [31:0] pix0_o,
  output logic [31:0] pix1_o,
  output logic [31:0] pix2_o,
  output logic [31:0] pix3_o,
  output logic        block_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import cbvd_pkg::*;

  logic [10:0]      width_q;
  logic [10:0]      height_q;
  logic             fmt_q;
  logic [10:0]      width_sat;
  logic [10:0]      height_sat;
  logic [GridW-1:0] cols;
  logic [GridW-1:0] rows;
  logic             push;
  logic             pop;
  desc_t            desc;
  desc_t            head;
  fifo_stat_t       q_stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      fmt_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
        REG_OUT_FORMAT:   fmt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Frame sizes saturate at the largest supported frame before the grid is derived.
  assign width_sat  = (width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q;
  assign height_sat = (height_q > 11'(MaxHeight)) ? 11'(MaxHeight) : height_q;
  assign cols       = width_sat[GridW+1:2];
  assign rows       = height_sat[GridW+1:2];

  cbvd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .word_i     (word_i),
    .cols_i     (cols),
    .rows_i     (rows),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .desc_o     (desc)
  );

  cbvd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .desc_i (desc),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  cbvd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .q_stat_i     (q_stat),
    .pop_o        (pop),
    .out_format_i (fmt_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .block_col_o  (block_col_o),
    .pixel_row_o  (pixel_row_o),
    .pix0_o       (pix0_o),
    .pix1_o       (pix1_o),
    .pix2_o       (pix2_o),
    .pix3_o       (pix3_o),
    .block_end_o  (block_end_o)
  );

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for cram_block_video_decoder: directed and random stream words
// against a block decoder predictor held in a small scoreboard class. Depends on cbvd_pkg.
module testbench;
  import cbvd_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int unsigned IdleLimit = 10000;
  localparam int unsigned SettleCycles = 1500;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;
  typedef enum logic [2:0] {OP_FRAME, OP_FILL, OP_SKIP, OP_PAIR, OP_QUAD, OP_NOISE} stream_op_e;

  typedef struct packed {
    logic [7:0]       col;
    logic [9:0]       prow;
    logic [3:0][31:0] pix;
    logic             last;
  } pixel_row_t;

  class frame_scoreboard;
    logic [10:0] width;
    logic [10:0] height;
    logic        fmt;
    logic [2:0]  phase;
    logic [15:0] mask;
    logic [14:0] colors[8];
    int          need;
    int          col;
    int          row;
    bit          done;
    pixel_row_t  pending_rows[$];
    int          words_seen;
    int          words_live;
    int          rows_checked;
    int          errors;

    function new();
      width  = WIDTH_RST;
      height = HEIGHT_RST;
      fmt    = 1'b0;
      phase  = PH_OPCODE;
      mask   = '0;
      foreach (colors[i]) colors[i] = '0;
      need   = 0;
      col    = 0;
      row    = 0;
      done   = 0;
      words_seen   = 0;
      words_live   = 0;
      rows_checked = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] d);
      case (idx)
        REG_FRAME_WIDTH:  width  = d;
        REG_FRAME_HEIGHT: height = d;
        REG_OUT_FORMAT:   fmt    = d[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] to_pixel(logic [14:0] c);
      logic [31:0] v;
      v = {17'd0, c};
      if (fmt) return (v & 32'h03E0) | ((v >> 10) & 32'h001F) | ((v << 10) & 32'h7C00);
      return 32'hFF00_0000 | ((v & 32'h7C00) << 9) | ((v & 32'h03E0) << 6) |
             ((v & 32'h001F) << 3);
    endfunction

    // Moves the block position on by n, wrapping across block rows; running off
    // the last row ends the frame.
    function void move_on(int n, int cols, int rows);
      int bx;
      int by;
      bx = col + n;
      by = row;
      while (bx >= cols) begin
        bx -= cols;
        by++;
        if (by >= rows) begin
          done = 1;
          bx = 0;
          by = 0;
          break;
        end
      end
      col = bx;
      row = by;
    endfunction

    function void queue_block(bit fill, logic [14:0] fill_color, bit quad, int rows);
      pixel_row_t e;
      int base;
      int pair;
      logic [14:0] c;
      base = (rows - 1 - row) * 4;
      for (int k = 0; k < 4; k++) begin
        e.col  = col[7:0];
        e.prow = 10'(base + 3 - k);
        for (int i = 0; i < 4; i++) begin
          if (fill) begin
            c = fill_color;
          end else begin
            pair = quad ? ((k >= 2 ? 2 : 0) + (i >= 2 ? 1 : 0)) : 0;
            c = colors[(pair * 2 + (mask[4 * k + i] ? 0 : 1)) & 7];
          end
          e.pix[i] = to_pixel(c);
        end
        e.last = (k == 3);
        pending_rows.push_back(e);
      end
    endfunction

    // Takes one accepted input beat; the words that a finished or empty frame
    // swallows are not counted as live.
    function void take_word(logic cmd, logic [15:0] w);
      int cols;
      int rows;
      int total;
      int n;
      bit quad;
      cols = int'(width > MaxWidth ? MaxWidth : width) >> 2;
      rows = int'(height > MaxHeight ? MaxHeight : height) >> 2;
      words_seen++;
      if (cmd) begin
        phase = PH_OPCODE;
        need  = 0;
        col   = 0;
        row   = 0;
        done  = 0;
        words_live++;
        return;
      end
      if (cols == 0 || rows == 0 || done || col >= cols || row >= rows) begin
        done  = 1;
        phase = PH_OPCODE;
        need  = 0;
        return;
      end
      words_live++;
      case (phase)
        PH_COLOR0: begin
          colors[0] = w[14:0];
          need  = w[15] ? 7 : 1;
          phase = w[15] ? PH_QUAD : PH_PAIR;
        end
        PH_PAIR, PH_QUAD: begin
          quad  = (phase == PH_QUAD);
          total = quad ? 8 : 2;
          n = need;
          if (n == 0 || n >= total) n = total - 1;
          colors[(total - n) & 7] = w[14:0];
          n--;
          need = n;
          if (n == 0) begin
            queue_block(0, '0, quad, rows);
            phase = PH_OPCODE;
            move_on(1, cols, rows);
          end
        end
        default: begin
          phase = PH_OPCODE;
          if (w[15]) begin
            if ((w & SKIP_MASK) == SKIP_CODE) begin
              move_on(int'(w[9:0]), cols, rows);
            end else begin
              queue_block(1, w[14:0], 0, rows);
              move_on(1, cols, rows);
            end
          end else begin
            mask  = w;
            phase = PH_COLOR0;
          end
        end
      endcase
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("row beat %0d: %s is %h, expected %h", rows_checked, what, got, want);
      errors++;
    endtask

    task check_row(logic [7:0] c, logic [9:0] prow, logic [3:0][31:0] pix, logic last);
      pixel_row_t e;
      rows_checked++;
      if (pending_rows.size() == 0) begin
        report("row with nothing pending, block_col", 32'(c), 32'd0);
        return;
      end
      e = pending_rows.pop_front();
      if (c !== e.col) report("block_col", 32'(c), 32'(e.col));
      if (prow !== e.prow) report("pixel_row", 32'(prow), 32'(e.prow));
      for (int i = 0; i < 4; i++)
        if (pix[i] !== e.pix[i]) report($sformatf("pix%0d", i), pix[i], e.pix[i]);
      if (last !== e.last) report("block_end", 32'(last), 32'(e.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        cmd = 1'b0;
  logic [15:0] word = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  block_col;
  logic [9:0]  pixel_row;
  logic [31:0] pix0, pix1, pix2, pix3;
  logic        block_end;
  logic        cfg_ready;

  idle_mode_e      mode = IDLE_NONE;
  frame_scoreboard sb;
  int              words_sent = 0;
  int              idle_cycles = 0;

  cram_block_video_decoder uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .cmd_i       (cmd),
    .word_i      (word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .block_col_o (block_col),
    .pixel_row_o (pixel_row),
    .pix0_o      (pix0),
    .pix1_o      (pix1),
    .pix2_o      (pix2),
    .pix3_o      (pix3),
    .block_end_o (block_end),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    case (mode)
      IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 82);
      IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 34);
      default:       out_ready <= 1'b1;
    endcase
  end

  // Beats are sampled with the values held before the edge, as the block sees them.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) sb.take_word(cmd, word);
      if (out_valid && out_ready)
        sb.check_row(block_col, pixel_row, {pix3, pix2, pix1, pix0}, block_end);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no beat for %0d cycles, %0d rows outstanding",
                 idle_cycles, sb.pending_rows.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // The valid is left high after a beat so that the next word can follow at once;
  // a gap lowers it first.
  task send_word(input logic c, input logic [15:0] w);
    int gap_pct;
    gap_pct = (mode == IDLE_SENDER) ? 82 : (mode == IDLE_BOTH) ? 34 : 0;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < gap_pct);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    word     <= w;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task cfg_write(input logic [1:0] idx, input logic [10:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task configure(input logic [10:0] w, input logic [10:0] h, input logic f);
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_OUT_FORMAT, {10'd0, f});
    cfg_write(REG_UNUSED, 11'($urandom));
  endtask

  // A skip word can keep the block busy after its beat without any row to show
  // for it, so a long pause follows the last row.
  task settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task send_op();
    stream_op_e  op;
    int          pick;
    logic [15:0] w;
    pick = $urandom_range(99);
    if (sb.done && pick < 70) op = OP_FRAME;
    else if (pick < 6)        op = OP_FRAME;
    else if (pick < 30)       op = OP_FILL;
    else if (pick < 40)       op = OP_SKIP;
    else if (pick < 70)       op = OP_PAIR;
    else if (pick < 92)       op = OP_QUAD;
    else                      op = OP_NOISE;
    case (op)
      OP_FRAME: send_word(1'b1, 16'($urandom));
      OP_FILL: begin
        do w = {1'b1, 15'($urandom)}; while ((w & SKIP_MASK) == SKIP_CODE);
        send_word(1'b0, w);
      end
      OP_SKIP: begin
        w = SKIP_CODE | 16'(($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(3));
        send_word(1'b0, w);
      end
      OP_PAIR: begin
        send_word(1'b0, {1'b0, 15'($urandom)});
        send_word(1'b0, {1'b0, 15'($urandom)});
        send_word(1'b0, 16'($urandom));
      end
      OP_QUAD: begin
        send_word(1'b0, {1'b0, 15'($urandom)});
        send_word(1'b0, {1'b1, 15'($urandom)});
        repeat (7) send_word(1'b0, 16'($urandom));
      end
      default: send_word(1'b0, 16'($urandom));
    endcase
  endtask

  // No new frame is forced at the start, so a smaller grid may find the old
  // position outside it.
  task run_phase(input logic [10:0] w, input logic [10:0] h, input logic f,
                 input idle_mode_e m, input int target);
    int live0;
    int sent0;
    settle();
    configure(w, h, f);
    mode  = m;
    live0 = sb.words_live;
    sent0 = words_sent;
    while (sb.words_live - live0 < target && words_sent - sent0 < 3 * target) send_op();
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A two by two block grid: fill, plain mask, skip of zero, quadrant mask and a
    // last fill that completes the frame, then words after completion and a skip
    // that runs past the end.
    configure(11'd8, 11'd8, 1'b0);
    send_word(1'b1, 16'hFFFF);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, 16'h7FFF);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, SKIP_CODE);
    send_word(1'b0, 16'h7FFF);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b0, 16'h8000);
    send_word(1'b0, 16'h7C00);
    send_word(1'b0, 16'h03E0);
    send_word(1'b0, 16'h001F);
    send_word(1'b0, 16'h5555);
    send_word(1'b0, 16'h2AAA);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b0, 16'h83FF);
    send_word(1'b0, 16'h0000);
    send_word(1'b0, 16'h8800);
    send_word(1'b1, 16'h0000);
    send_word(1'b0, 16'h87FF);
    send_word(1'b0, 16'hFFFF);
    send_word(1'b1, 16'h0000);
    send_word(1'b0, 16'h8800);
    send_word(1'b0, 16'hFFFF);

    run_phase(11'd16,   11'd12,   1'b1, IDLE_NONE,     22);
    run_phase(11'd2047, 11'd4,    1'b0, IDLE_SENDER,   18);
    run_phase(11'd4,    11'd2047, 1'b1, IDLE_RECEIVER, 22);
    run_phase(11'd20,   11'd16,   1'b0, IDLE_BOTH,     22);
    run_phase(11'd3,    11'd1024, 1'b1, IDLE_BOTH,     4);
    run_phase(11'd320,  11'd240,  1'b0, IDLE_NONE,     22);

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d stream words (%0d decoded), %0d pixel rows checked, %0d mismatches",
             sb.words_seen, sb.words_live, sb.rows_checked, sb.errors);
    $display("covered seven grid settings incl. tiny and saturated frames, both formats");
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
